// File: design/psc_pkg.sv
package psc_pkg;

    localparam int IN_W    = 16;
    localparam int MS_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int ERR_W   = IN_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ACC_W   = 27;
    localparam int MA_W    = 28;
    localparam int MB_W    = 17;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DRV_W   = 9;

    localparam int DRIVE_LIMIT_DEF = 255;
    localparam int MS_PER_S        = 1000;
    localparam int SUM_SHIFT       = 12;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THR   = 3'd4;

    localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [CFG_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] DERIV_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] INTEG_LIM_RST  = 16'd1600;
    localparam logic [CFG_W-1:0] JUMP_THR_RST   = 16'd160;

    typedef enum logic [2:0] {
        MUL_LIM  = 3'd0,
        MUL_EMS  = 3'd1,
        MUL_DIFF = 3'd2,
        MUL_IG   = 3'd3,
        MUL_PG   = 3'd4,
        MUL_DG   = 3'd5
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     check;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     lim_load;
        logic     acc_update;
        logic     div_start;
        logic     div_by_ms;
        logic     deriv_load;
        logic     sum_load;
        logic     sum_add_prod;
        logic     sum_add_quo;
        logic     finish;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic first_eff;
        logic ms_zero;
        logic div_busy;
    } t_sts;

endpackage

// File: design/psc_div.sv
module psc_div #(
    parameter int N_W = psc_pkg::PROD_W,
    parameter int D_W = psc_pkg::MS_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [N_W-1:0] i_num,
    input  logic        [D_W-1:0] i_den,
    output logic                  o_busy,
    output logic signed [N_W-1:0] o_quo
);

    localparam int M_W   = N_W - 1;
    localparam int STEPS = (M_W + 1) / 2;
    localparam int Q_W   = 2 * STEPS;
    localparam int C_W   = $clog2(STEPS + 1);

    logic [D_W-1:0] r_rem, n_rem;
    logic [Q_W-1:0] r_quo, n_quo;
    logic [D_W-1:0] r_den;
    logic           r_neg;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;

    logic [N_W-1:0] num_mag;
    logic [N_W-1:0] quo_ext;

    assign num_mag = i_num[N_W-1] ? N_W'(-i_num) : N_W'(i_num);

    always_comb begin
        logic [D_W:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_quo[Q_W-1]};
            n_quo = {n_quo[Q_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t        = t - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = t[D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= C_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == C_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= Q_W'(num_mag[M_W-1:0]);
            r_den <= i_den;
            r_neg <= i_num[N_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign quo_ext = {1'b0, r_quo[M_W-1:0]};
    assign o_quo   = r_neg ? $signed(-quo_ext) : $signed(quo_ext);
    assign o_busy  = r_busy;

endmodule

// File: design/psc_ctrl.sv
module psc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  psc_pkg::t_sts  i_sts,
    output psc_pkg::t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CHECK  = 13'b0000000000010,
        S_MLIM   = 13'b0000000000100,
        S_MEMS   = 13'b0000000001000,
        S_ACC    = 13'b0000000010000,
        S_DSTART = 13'b0000000100000,
        S_DWAIT  = 13'b0000001000000,
        S_ISTART = 13'b0000010000000,
        S_PSUM   = 13'b0000100000000,
        S_DSUM   = 13'b0001000000000,
        S_IWAIT  = 13'b0010000000000,
        S_FIN    = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    psc_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (i_sts.first_eff || i_sts.ms_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MLIM;
                end
            end
            S_MLIM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = psc_pkg::MUL_LIM;
                n_state     = S_MEMS;
            end
            S_MEMS: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = psc_pkg::MUL_EMS;
                cmd.lim_load = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                cmd.acc_update = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = psc_pkg::MUL_DIFF;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_by_ms = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = psc_pkg::MUL_IG;
                n_state       = S_DWAIT;
            end
            S_DWAIT: begin
                if (!i_sts.div_busy) begin
                    cmd.deriv_load = 1'b1;
                    n_state        = S_ISTART;
                end
            end
            S_ISTART: begin
                cmd.div_start = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = psc_pkg::MUL_PG;
                n_state       = S_PSUM;
            end
            S_PSUM: begin
                cmd.sum_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = psc_pkg::MUL_DG;
                n_state      = S_DSUM;
            end
            S_DSUM: begin
                cmd.sum_add_prod = 1'b1;
                n_state          = S_IWAIT;
            end
            S_IWAIT: begin
                if (!i_sts.div_busy) begin
                    cmd.sum_add_quo = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: design/psc_dp.sv
module psc_dp #(
    parameter int DRIVE_LIMIT = psc_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [psc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [psc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic signed [psc_pkg::IN_W-1:0]       i_measured_rpm,
    input  logic signed [psc_pkg::IN_W-1:0]       i_target_rpm,
    input  logic        [psc_pkg::MS_W-1:0]       i_elapsed_ms,
    input  psc_pkg::t_cmd                         i_cmd,
    output psc_pkg::t_sts                         o_sts,
    output logic signed [psc_pkg::DRV_W-1:0]      o_drive
);

    localparam int IN_W   = psc_pkg::IN_W;
    localparam int ERR_W  = psc_pkg::ERR_W;
    localparam int DIFF_W = psc_pkg::DIFF_W;
    localparam int ACC_W  = psc_pkg::ACC_W;
    localparam int MA_W   = psc_pkg::MA_W;
    localparam int MB_W   = psc_pkg::MB_W;
    localparam int PROD_W = psc_pkg::PROD_W;
    localparam int DRV_W  = psc_pkg::DRV_W;
    localparam int GAIN_W = psc_pkg::GAIN_W;
    localparam int MS_W   = psc_pkg::MS_W;
    localparam int ASUM_W = ACC_W + 7;
    localparam logic signed [PROD_W-1:0] LIMIT_S   = PROD_W'(DRIVE_LIMIT);
    localparam logic signed [PROD_W-1:0] ROUND_ADJ =
        PROD_W'((1 << psc_pkg::SUM_SHIFT) - 1);

    logic signed [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic        [GAIN_W-1:0] r_integ_lim, r_jump_thr;

    logic signed [IN_W-1:0]   r_meas, r_targ, r_held;
    logic        [MS_W-1:0]   r_ms;
    logic signed [ERR_W-1:0]  r_err, r_prev_err;
    logic signed [ACC_W-1:0]  r_acc, r_lim;
    logic                     r_first;
    logic signed [MA_W-1:0]   r_deriv;
    logic signed [PROD_W-1:0] r_prod, r_sum;
    logic signed [DRV_W-1:0]  r_prev_drive, r_result, r_drive_out;

    logic signed [ERR_W-1:0]  jdiff, err;
    logic        [ERR_W-1:0]  jabs;
    logic                     jump;
    logic signed [DIFF_W-1:0] ediff;
    logic signed [MA_W-1:0]   ma;
    logic signed [MB_W-1:0]   mb;
    logic signed [PROD_W-1:0] mprod;
    logic signed [ASUM_W-1:0] asum, alim;
    logic signed [ACC_W-1:0]  acc_clamped;
    logic signed [PROD_W-1:0] adj, shifted, sat;
    logic signed [PROD_W-1:0] w_quo;
    logic        [MS_W-1:0]   div_den;
    logic                     div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= psc_pkg::PROP_GAIN_RST;
            r_integ_gain <= psc_pkg::INTEG_GAIN_RST;
            r_deriv_gain <= psc_pkg::DERIV_GAIN_RST;
            r_integ_lim  <= psc_pkg::INTEG_LIM_RST;
            r_jump_thr   <= psc_pkg::JUMP_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psc_pkg::CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                psc_pkg::CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                psc_pkg::CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                psc_pkg::CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data;
                psc_pkg::CFG_JUMP_THR:   r_jump_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign jdiff = ERR_W'(r_targ) - ERR_W'(r_held);
    assign jabs  = jdiff[ERR_W-1] ? ERR_W'(-jdiff) : ERR_W'(jdiff);
    assign jump  = jabs > {1'b0, r_jump_thr};
    assign err   = ERR_W'(r_targ) - ERR_W'(r_meas);
    assign ediff = DIFF_W'(r_err) - DIFF_W'(r_prev_err);

    assign o_sts.first_eff = r_first | jump;
    assign o_sts.ms_zero   = (r_ms == '0);
    assign o_sts.div_busy  = div_busy;

    always_comb begin
        case (i_cmd.mul_sel)
            psc_pkg::MUL_LIM: begin
                ma = $signed(MA_W'(r_integ_lim));
                mb = MB_W'(psc_pkg::MS_PER_S);
            end
            psc_pkg::MUL_EMS: begin
                ma = MA_W'(r_err);
                mb = $signed({1'b0, r_ms});
            end
            psc_pkg::MUL_DIFF: begin
                ma = MA_W'(ediff);
                mb = MB_W'(psc_pkg::MS_PER_S);
            end
            psc_pkg::MUL_IG: begin
                ma = MA_W'(r_acc);
                mb = MB_W'(r_integ_gain);
            end
            psc_pkg::MUL_PG: begin
                ma = MA_W'(r_err);
                mb = MB_W'(r_prop_gain);
            end
            psc_pkg::MUL_DG: begin
                ma = r_deriv;
                mb = MB_W'(r_deriv_gain);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mprod = ma * mb;

    always_comb begin
        asum = ASUM_W'(r_acc) + $signed(r_prod[ASUM_W-1:0]);
        alim = ASUM_W'(r_lim);
        if (asum > alim) begin
            acc_clamped = r_lim;
        end else if (asum < -alim) begin
            acc_clamped = -r_lim;
        end else begin
            acc_clamped = ACC_W'(asum);
        end
    end

    always_comb begin
        adj     = r_sum + (r_sum[PROD_W-1] ? ROUND_ADJ : '0);
        shifted = adj >>> psc_pkg::SUM_SHIFT;
        if (shifted > LIMIT_S) begin
            sat = LIMIT_S;
        end else if (shifted < -LIMIT_S) begin
            sat = -LIMIT_S;
        end else begin
            sat = shifted;
        end
    end

    assign div_den = i_cmd.div_by_ms ? r_ms : MS_W'(psc_pkg::MS_PER_S);

    psc_div #(
        .N_W (PROD_W),
        .D_W (MS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_prev_err   <= '0;
            r_held       <= '0;
            r_first      <= 1'b1;
            r_prev_drive <= '0;
        end else begin
            if (i_cmd.check) begin
                r_held <= r_targ;
                if (r_first || jump) begin
                    r_prev_err <= err;
                    r_first    <= 1'b0;
                    if (jump) begin
                        r_acc <= '0;
                    end
                end
            end
            if (i_cmd.acc_update) begin
                r_acc <= acc_clamped;
            end
            if (i_cmd.finish) begin
                r_prev_err   <= r_err;
                r_prev_drive <= sat[DRV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas <= i_measured_rpm;
            r_targ <= i_target_rpm;
            r_ms   <= i_elapsed_ms;
        end
        if (i_cmd.check) begin
            r_err <= err;
            if (r_first || jump) begin
                r_result <= '0;
            end else begin
                r_result <= r_prev_drive;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= mprod;
        end
        if (i_cmd.lim_load) begin
            r_lim <= $signed(r_prod[ACC_W-1:0]);
        end
        if (i_cmd.deriv_load) begin
            r_deriv <= $signed(w_quo[MA_W-1:0]);
        end
        if (i_cmd.sum_load) begin
            r_sum <= r_prod;
        end else if (i_cmd.sum_add_prod) begin
            r_sum <= r_sum + r_prod;
        end else if (i_cmd.sum_add_quo) begin
            r_sum <= r_sum + w_quo;
        end
        if (i_cmd.finish) begin
            r_result <= sat[DRV_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_drive_out <= r_result;
        end
    end

    assign o_drive = r_drive_out;

endmodule

// File: design/pid_speed_controller.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_measured_rpm, i_target_rpm, i_elapsed_ms
// result    out        o_out_valid / i_out_ready o_drive
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One request at a time. A first sample after a clear or a target jump, or a zero elapsed
// time, skips the arithmetic and goes straight to the output stage; a full update makes two
// passes of the shared radix-4 divider and uses the shared multiplier.
// Synchronous active-low reset clears the controller state and loads register defaults.
// A stalled result holds in the output register; a new request is taken meanwhile and
// its result waits until the output register frees.
module pid_speed_controller #(
    parameter int DRIVE_LIMIT = psc_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [psc_pkg::IN_W-1:0]       i_measured_rpm,
    input  logic signed [psc_pkg::IN_W-1:0]       i_target_rpm,
    input  logic        [psc_pkg::MS_W-1:0]       i_elapsed_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [psc_pkg::DRV_W-1:0]      o_drive,
    input  logic                                  i_cfg_we,
    input  logic        [psc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [psc_pkg::CFG_W-1:0]      i_cfg_data
);

    psc_pkg::t_cmd cmd;
    psc_pkg::t_sts sts;

    psc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    psc_dp #(
        .DRIVE_LIMIT (DRIVE_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_measured_rpm (i_measured_rpm),
        .i_target_rpm   (i_target_rpm),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_drive        (o_drive)
    );

endmodule

// File: design/psc_chk.sv
module psc_chk #(
    parameter int DRIVE_LIMIT = psc_pkg::DRIVE_LIMIT_DEF
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic signed [psc_pkg::IN_W-1:0]       i_measured_rpm,
    input logic signed [psc_pkg::IN_W-1:0]       i_target_rpm,
    input logic        [psc_pkg::MS_W-1:0]       i_elapsed_ms,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [psc_pkg::DRV_W-1:0]      o_drive,
    input logic                                  i_cfg_we,
    input logic        [psc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic        [psc_pkg::CFG_W-1:0]      i_cfg_data
);

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not leave block idle and empty");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while previous one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive))
        else $error("stalled result changed");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DRIVE_LIMIT <= 255) |-> o_drive != 9'h100)
        else $error("drive outside saturation range");

endmodule

bind pid_speed_controller psc_chk #(.DRIVE_LIMIT(DRIVE_LIMIT)) u_psc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_measured_rpm (i_measured_rpm),
    .i_target_rpm   (i_target_rpm),
    .i_elapsed_ms   (i_elapsed_ms),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_drive        (o_drive),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_idx      (i_cfg_idx),
    .i_cfg_data     (i_cfg_data)
);

// File: sim/psc_checker.sv
module psc_checker
    import psc_pkg::*;
#(
    parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic signed [IN_W-1:0]       i_measured_rpm,
    input  logic signed [IN_W-1:0]       i_target_rpm,
    input  logic        [MS_W-1:0]       i_elapsed_ms,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic        [DRV_W-1:0]      i_drive,
    input  logic                         i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [CFG_W-1:0]      i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_jumps,
    output int                           o_holds,
    output int                           o_clamps,
    output int                           o_sats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 20;

    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic        [CFG_W-1:0]  int_lim;
    logic        [CFG_W-1:0]  jump_thr;

    longint integ_acc;
    longint last_err;
    longint last_target;
    longint last_drive;
    bit     first_pend;

    logic [DRV_W-1:0] drive_q[$];

    int mism;
    int checked;
    int jumps;
    int holds;
    int clamps;
    int sats;

    task automatic report(input string what, input logic [DRV_W-1:0] got,
                          input logic [DRV_W-1:0] want);
        if (mism < MAX_PRINTED) begin
            $display("[%0t] drive mismatch (%s): got %0d expected %0d", $time, what,
                     $signed(got), $signed(want));
        end
        mism++;
    endtask

    function automatic logic [DRV_W-1:0] compute_drive(input longint meas, input longint targ,
                                                        input longint ms);
        longint span;
        longint err;
        longint bound;
        longint rate;
        longint total;
        longint drv;
        span = targ - last_target;
        if (span < 0) span = -span;
        if (span > longint'(jump_thr)) begin
            integ_acc  = 0;
            last_err   = 0;
            first_pend = 1'b1;
            jumps++;
        end
        last_target = targ;
        err = targ - meas;
        if (first_pend) begin
            last_err   = err;
            first_pend = 1'b0;
            return '0;
        end
        if (ms == 0) begin
            holds++;
            return last_drive[DRV_W-1:0];
        end
        bound = longint'(int_lim) * MS_PER_S;
        integ_acc = integ_acc + err * ms;
        if (integ_acc > bound) begin
            integ_acc = bound;
            clamps++;
        end else if (integ_acc < -bound) begin
            integ_acc = -bound;
            clamps++;
        end
        rate  = (err - last_err) * MS_PER_S / ms;
        total = longint'(kp) * err + longint'(ki) * integ_acc / MS_PER_S + longint'(kd) * rate;
        drv   = total / (longint'(1) << SUM_SHIFT);
        if (drv > DRIVE_LIMIT) begin
            drv = DRIVE_LIMIT;
            sats++;
        end else if (drv < -DRIVE_LIMIT) begin
            drv = -DRIVE_LIMIT;
            sats++;
        end
        last_err   = err;
        last_drive = drv;
        return drv[DRV_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DRV_W-1:0] want;
        if (!i_rst_n) begin
            kp          = PROP_GAIN_RST;
            ki          = INTEG_GAIN_RST;
            kd          = DERIV_GAIN_RST;
            int_lim     = INTEG_LIM_RST;
            jump_thr    = JUMP_THR_RST;
            integ_acc   = 0;
            last_err    = 0;
            last_target = 0;
            last_drive  = 0;
            first_pend  = 1'b1;
            drive_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    report("no request pending", i_drive, 'x);
                end else begin
                    want = drive_q.pop_front();
                    checked++;
                    if (i_drive !== want) report("value", i_drive, want);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:  kp       = i_cfg_data;
                    CFG_INTEG_GAIN: ki       = i_cfg_data;
                    CFG_DERIV_GAIN: kd       = i_cfg_data;
                    CFG_INTEG_LIM:  int_lim  = i_cfg_data;
                    CFG_JUMP_THR:   jump_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                drive_q.push_back(compute_drive(longint'(i_measured_rpm),
                                                longint'(i_target_rpm),
                                                longint'(i_elapsed_ms)));
            end
        end
        o_mismatches <= mism;
        o_pending    <= drive_q.size();
        o_checked    <= checked;
        o_jumps      <= jumps;
        o_holds      <= holds;
        o_clamps     <= clamps;
        o_sats       <= sats;
    end

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_REQUESTS  = 171;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic signed [IN_W-1:0]       i_measured_rpm = '0;
    logic signed [IN_W-1:0]       i_target_rpm = '0;
    logic        [MS_W-1:0]       i_elapsed_ms = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [DRV_W-1:0]      o_drive;
    logic                         i_cfg_we = 1'b0;
    logic        [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic        [CFG_W-1:0]      i_cfg_data = '0;

    int mismatches;
    int pending;
    int checked;
    int jumps;
    int holds;
    int clamps;
    int sats;

    int     cycle_count = 0;
    int     requests = 0;
    int     settings = 0;
    int     burst_left = 0;
    int     thr_now = 0;
    longint held_tgt = 0;
    bit     hold_off_req = 1'b0;

    always #1 i_clk = ~i_clk;

    pid_speed_controller i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_measured_rpm (i_measured_rpm),
        .i_target_rpm   (i_target_rpm),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive        (o_drive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    psc_checker u_drive_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_measured_rpm (i_measured_rpm),
        .i_target_rpm   (i_target_rpm),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_drive        (o_drive),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_jumps        (jumps),
        .o_holds        (holds),
        .o_clamps       (clamps),
        .o_sats         (sats)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("** pid_speed_controller: FAILED **");
            $finish;
        end
    end

    // result side: stall pattern of its own, plus one long hold-off on request
    initial begin
        int ready_pct;
        int mode_left;
        ready_pct = 100;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left <= 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                i_out_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    function automatic logic signed [IN_W-1:0] sat16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[IN_W-1:0];
    endfunction

    task automatic send_request(input logic signed [IN_W-1:0] meas,
                                input logic signed [IN_W-1:0] targ,
                                input logic [MS_W-1:0] ms);
        int gap;
        i_in_valid     <= 1'b1;
        i_measured_rpm <= meas;
        i_target_rpm   <= targ;
        i_elapsed_ms   <= ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests++;
        held_tgt = longint'(targ);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_request();
        int              pick;
        int              ms_pick;
        int              span;
        int              spread;
        longint          tgt;
        longint          meas;
        logic [MS_W-1:0] ms;
        pick    = $urandom_range(0, 99);
        ms_pick = $urandom_range(0, 99);
        if (ms_pick < 5)       ms = '0;
        else if (ms_pick < 85) ms = MS_W'($urandom_range(1, 50));
        else if (ms_pick < 95) ms = MS_W'($urandom_range(51, 1000));
        else                   ms = MS_W'($urandom_range(1001, 65535));
        if (pick < 8) begin
            send_request(16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            if (pick < 14) begin
                tgt = longint'($signed(16'($urandom)));
            end else begin
                span = (thr_now < 400) ? thr_now : 400;
                tgt  = held_tgt + longint'($urandom_range(0, 2 * span)) - span;
            end
            spread = ($urandom_range(0, 3) == 0) ? 4000 : 200;
            meas   = tgt + longint'($urandom_range(0, 2 * spread)) - spread;
            send_request(sat16(meas), sat16(tgt), ms);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                              input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] lim,
                              input logic [CFG_W-1:0] thr);
        wait_idle();
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_INTEG_LIM, lim);
        write_reg(CFG_JUMP_THR, thr);
        i_cfg_we <= 1'b0;
        thr_now = int'(thr);
        settings++;
    endtask

    task automatic random_phase();
        repeat (PHASE_REQUESTS) random_request();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(16'd256, 16'd512, 16'd64, 16'd100, 16'd160);
        send_request(16'sd0, 16'sd0, 16'd10);
        send_request(-16'sd160, 16'sd0, 16'd10);
        send_request(16'sd0, 16'sd0, 16'd0);
        send_request(16'sd0, 16'sd160, 16'd5);
        send_request(16'sd0, 16'sd321, 16'd5);
        send_request(16'sd0, 16'sd321, 16'd0);
        send_request(16'sh8000, 16'sd321, 16'hFFFF);
        send_request(16'sh7FFF, 16'sd321, 16'd1);
        send_request(16'sh7FFF, 16'sd321, 16'd1);
        send_request(16'sh8000, 16'sh7FFF, 16'd1);
        send_request(16'sh8000, 16'sh7FFF, 16'd1);
        send_request(16'sh7FFF, 16'sh8000, 16'd7);
        send_request(16'sh7FFF, 16'sh8000, 16'd3);
        send_request(16'sh7FFF, 16'sh8000, 16'd0);
        send_request(16'sh8000, 16'sh8000, 16'hFFFF);

        set_config(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_request(16'sh8000, 16'sh7FFF, 16'hFFFF);
        send_request(16'sh7FFF, 16'sh8000, 16'hFFFF);
        send_request(16'sh7FFF, 16'sh8000, 16'd1);
        send_request(16'sd0, 16'sd0, 16'd2);
        send_request(16'sd100, 16'sd0, 16'd0);

        set_config(16'd256, 16'd256, 16'd256, 16'd0, 16'd0);
        send_request(16'sd5, 16'sd0, 16'd3);
        send_request(16'sd5, 16'sd1, 16'd3);
        send_request(-16'sd5, 16'sd1, 16'd3);
        send_request(-16'sd5, 16'sd1, 16'd0);

        set_config(16'd256, 16'd64, 16'd32, 16'd1600, 16'd160);
        random_phase();
        set_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        random_phase();
        set_config(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0);
        random_phase();
        set_config(16'($urandom_range(0, 2048) - 1024), 16'($urandom_range(0, 2048) - 1024),
                   16'($urandom_range(0, 2048) - 1024), 16'($urandom_range(0, 4000)),
                   16'($urandom_range(0, 800)));
        hold_off_req = 1'b1;
        random_phase();
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_phase();
        set_config(16'd512, -16'sd256, 16'd0, 16'd1, 16'd32);
        random_phase();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d requests under %0d register settings, %0d drive results checked",
                 requests, settings, checked);
        $display("seen: %0d target jumps, %0d zero-interval repeats, %0d integral clamps, %0d saturated drives",
                 jumps, holds, clamps, sats);
        if (mismatches == 0 && pending == 0) begin
            $display("** pid_speed_controller: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending);
            $display("** pid_speed_controller: FAILED **");
        end
        $finish;
    end

endmodule
